// ===== rtl/qte_pkg.sv =====
`timescale 1ns / 1ps
package qte_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int QW               = 16;  // quaternion component width
    localparam int AW               = 35;  // atan2 / asin argument width, Q.28
    localparam int PW               = 32;  // partial product width
    localparam int XW               = 38;  // cordic x/y datapath width
    localparam int ZW               = 27;  // cordic angle accumulator, degrees Q.16
    localparam int OW               = 15;  // output angle width, degrees Q.6
    localparam int RW               = 58;  // square root working width
    localparam int ISQ_STAGES       = 29;  // one result bit per stage
    localparam int DEG180_OUT       = 11520;
    localparam int DEG90_OUT        = 5760;
    localparam int DEG180_ACC       = 180 * 65536;

    typedef logic signed [AW-1:0] t_arg;
    typedef logic signed [OW-1:0] t_ang;

    // atan(2^-i) in degrees at scale 2^16
    function automatic logic signed [ZW-1:0] atan_tab(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0:  v = 27'sd2949120;
            1:  v = 27'sd1740967;
            2:  v = 27'sd919879;
            3:  v = 27'sd466945;
            4:  v = 27'sd234379;
            5:  v = 27'sd117304;
            6:  v = 27'sd58666;
            7:  v = 27'sd29335;
            8:  v = 27'sd14668;
            9:  v = 27'sd7334;
            10: v = 27'sd3667;
            11: v = 27'sd1833;
            12: v = 27'sd917;
            13: v = 27'sd458;
            14: v = 27'sd229;
            15: v = 27'sd115;
            16: v = 27'sd57;
            17: v = 27'sd29;
            18: v = 27'sd14;
            19: v = 27'sd7;
            20: v = 27'sd4;
            21: v = 27'sd2;
            22: v = 27'sd1;
            default: v = 27'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/qte_products.sv =====
`timescale 1ns / 1ps
module qte_products import qte_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [QW-1:0] i_w,
    input  logic signed [QW-1:0] i_x,
    input  logic signed [QW-1:0] i_y,
    input  logic signed [QW-1:0] i_z,
    output logic                 o_valid,
    output t_arg                 o_sinr,
    output t_arg                 o_cosr,
    output t_arg                 o_siny,
    output t_arg                 o_cosy,
    output t_arg                 o_sinp,
    output logic                 o_clamp,
    output logic [56:0]          o_rem
);

    logic signed [PW-1:0] r_wx, r_yz, r_xx, r_yy, r_zz, r_wy, r_zx, r_wz, r_xy;
    logic                 r_va, r_vb, r_vc;
    t_arg                 r_sinr, r_cosr, r_siny, r_cosy, r_sinp;
    t_arg                 r2_sinr, r2_cosr, r2_siny, r2_cosy, r2_sinp;
    logic                 r_clamp, r2_clamp;
    logic [27:0]          r_mag;
    logic [56:0]          r_rem;
    t_arg                 n_sinp;
    t_arg                 n_abs;
    logic [55:0]          n_sq;

    localparam t_arg QONE = t_arg'(64'sd1 <<< 28);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    always_comb begin
        n_sinp = (t_arg'(r_wy) - t_arg'(r_zx)) <<< 1;
        n_abs  = n_sinp[AW-1] ? -n_sinp : n_sinp;
        n_sq   = r_mag * r_mag;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // products
            r_wx <= i_w * i_x;
            r_yz <= i_y * i_z;
            r_xx <= i_x * i_x;
            r_yy <= i_y * i_y;
            r_zz <= i_z * i_z;
            r_wy <= i_w * i_y;
            r_zx <= i_z * i_x;
            r_wz <= i_w * i_z;
            r_xy <= i_x * i_y;
            // sums, Q.28
            r_sinr  <= (t_arg'(r_wx) + t_arg'(r_yz)) <<< 1;
            r_cosr  <= QONE - ((t_arg'(r_xx) + t_arg'(r_yy)) <<< 1);
            r_siny  <= (t_arg'(r_wz) + t_arg'(r_xy)) <<< 1;
            r_cosy  <= QONE - ((t_arg'(r_yy) + t_arg'(r_zz)) <<< 1);
            r_sinp  <= n_sinp;
            r_clamp <= (n_sinp >= QONE) || (n_sinp <= -QONE);
            r_mag   <= ((n_sinp >= QONE) || (n_sinp <= -QONE)) ? '0 : n_abs[27:0];
            // cosine term argument for the square root
            r2_sinr  <= r_sinr;
            r2_cosr  <= r_cosr;
            r2_siny  <= r_siny;
            r2_cosy  <= r_cosy;
            r2_sinp  <= r_sinp;
            r2_clamp <= r_clamp;
            r_rem    <= (57'd1 << 56) - {1'b0, n_sq};
        end
    end

    assign o_valid = r_vc;
    assign o_sinr  = r2_sinr;
    assign o_cosr  = r2_cosr;
    assign o_siny  = r2_siny;
    assign o_cosy  = r2_cosy;
    assign o_sinp  = r2_sinp;
    assign o_clamp = r2_clamp;
    assign o_rem   = r_rem;

endmodule

// ===== rtl/qte_isqrt.sv =====
`timescale 1ns / 1ps
module qte_isqrt import qte_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [56:0] i_rem,
    output logic        o_valid,
    output logic [28:0] o_root
);

    logic [RW-1:0] r_v [ISQ_STAGES];
    logic [RW-1:0] r_r [ISQ_STAGES];
    logic          r_vld [ISQ_STAGES];

    genvar k;
    generate
        for (k = 0; k < ISQ_STAGES; k++) begin : g_stage
            localparam logic [RW-1:0] BIT = RW'(1) << (56 - 2 * k);
            logic [RW-1:0] p_v, p_r, sum;
            logic          p_vld;
            if (k == 0) begin : g_first
                assign p_v   = {1'b0, i_rem};
                assign p_r   = '0;
                assign p_vld = i_valid;
            end else begin : g_next
                assign p_v   = r_v[k-1];
                assign p_r   = r_r[k-1];
                assign p_vld = r_vld[k-1];
            end
            assign sum = p_r + BIT;
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (i_en) begin
                    r_vld[k] <= p_vld;
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (p_v >= sum) begin
                        r_v[k] <= p_v - sum;
                        r_r[k] <= (p_r >> 1) + BIT;
                    end else begin
                        r_v[k] <= p_v;
                        r_r[k] <= p_r >> 1;
                    end
                end
            end
        end
    endgenerate

    assign o_valid = r_vld[ISQ_STAGES-1];
    assign o_root  = r_r[ISQ_STAGES-1][28:0];

endmodule

// ===== rtl/qte_cordic.sv =====
`timescale 1ns / 1ps
module qte_cordic import qte_pkg::*; #(
    parameter int Steps = CORDIC_STEPS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_arg i_y,
    input  t_arg i_x,
    output logic o_valid,
    output t_ang o_angle
);

    logic signed [XW-1:0] r_x [Steps+1];
    logic signed [XW-1:0] r_y [Steps+1];
    logic signed [ZW-1:0] r_z [Steps+1];
    logic                 r_sp [Steps+1];
    t_ang                 r_spv [Steps+1];
    logic                 r_vld [Steps+2];
    t_ang                 r_out;

    logic signed [XW-1:0] n_x, n_y;
    logic signed [ZW-1:0] n_z;
    logic                 n_sp;
    t_ang                 n_spv;
    logic [ZW-1:0]        n_mag;
    logic [16:0]          n_rnd;
    t_ang                 n_ang;

    // quadrant fold and the exact special angles
    always_comb begin
        n_x   = XW'(i_x);
        n_y   = XW'(i_y);
        n_z   = '0;
        n_sp  = 1'b0;
        n_spv = '0;
        if (i_y == '0) begin
            n_sp  = 1'b1;
            n_spv = i_x[AW-1] ? t_ang'(DEG180_OUT) : '0;
        end else if (i_x == '0) begin
            n_sp  = 1'b1;
            n_spv = i_y[AW-1] ? -t_ang'(DEG90_OUT) : t_ang'(DEG90_OUT);
        end
        if (i_x[AW-1]) begin
            n_z = i_y[AW-1] ? -ZW'(DEG180_ACC) : ZW'(DEG180_ACC);
            n_x = -XW'(i_x);
            n_y = -XW'(i_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= n_x;
            r_y[0]   <= n_y;
            r_z[0]   <= n_z;
            r_sp[0]  <= n_sp;
            r_spv[0] <= n_spv;
        end
    end

    genvar i;
    generate
        for (i = 0; i < Steps; i++) begin : g_step
            localparam logic signed [ZW-1:0] ANG = atan_tab(i);
            logic signed [XW-1:0] dx, dy;
            assign dx = r_y[i] >>> i;
            assign dy = r_x[i] >>> i;
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[i+1] <= 1'b0;
                end else if (i_en) begin
                    r_vld[i+1] <= r_vld[i];
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (!r_y[i][XW-1]) begin
                        r_x[i+1] <= r_x[i] + dx;
                        r_y[i+1] <= r_y[i] - dy;
                        r_z[i+1] <= r_z[i] + ANG;
                    end else begin
                        r_x[i+1] <= r_x[i] - dx;
                        r_y[i+1] <= r_y[i] + dy;
                        r_z[i+1] <= r_z[i] - ANG;
                    end
                    r_sp[i+1]  <= r_sp[i];
                    r_spv[i+1] <= r_spv[i];
                end
            end
        end
    endgenerate

    // round Q.16 to Q.6 half away from zero, then saturate
    always_comb begin
        n_mag = r_z[Steps][ZW-1] ? ZW'(-r_z[Steps]) : ZW'(r_z[Steps]);
        n_rnd = 17'((n_mag + ZW'(512)) >> 10);
        if (n_rnd > 17'(DEG180_OUT)) begin
            n_rnd = 17'(DEG180_OUT);
        end
        n_ang = r_z[Steps][ZW-1] ? -t_ang'(n_rnd) : t_ang'(n_rnd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[Steps+1] <= 1'b0;
        end else if (i_en) begin
            r_vld[Steps+1] <= r_vld[Steps];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= r_sp[Steps] ? r_spv[Steps] : n_ang;
        end
    end

    assign o_valid = r_vld[Steps+1];
    assign o_angle = r_out;

endmodule

// ===== rtl/quaternion_to_euler_angles.sv =====
`timescale 1ns / 1ps
// datapath: products, square root, three cordics, then the output register
// throughput: one quaternion per cycle; the pipeline advances whenever the output
//   register is empty or being taken, so a stall holds every stage in place
// reset: synchronous active-low i_rst_n clears all stage valid bits; no other state
module quaternion_to_euler_angles import qte_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,  // quat_w, quat_x, quat_y, quat_z (16 bits each)
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,  // roll_deg (15), pitch_deg (14), yaw_deg (15), zero pad
    output logic        o_m_axis_tuser   // pitch_clamped
);

    // flags must ride through the square root and the cordic
    localparam int FLAG_DEPTH = ISQ_STAGES + CORDIC_STEPS + 2;

    logic en;

    logic        p_valid, p_clamp;
    t_arg        p_sinr, p_cosr, p_siny, p_cosy, p_sinp;
    logic [56:0] p_rem;

    logic        s_valid;
    logic [28:0] s_root;

    t_arg r_d_sinr [ISQ_STAGES];
    t_arg r_d_cosr [ISQ_STAGES];
    t_arg r_d_siny [ISQ_STAGES];
    t_arg r_d_cosy [ISQ_STAGES];
    t_arg r_d_sinp [ISQ_STAGES];
    logic [1:0] r_flag [FLAG_DEPTH];   // {sign of pitch argument, clamp}

    logic c_roll_v, c_pitch_v, c_yaw_v;
    t_ang c_roll, c_pitch, c_yaw;

    logic        r_out_valid;
    logic [47:0] r_out_data;
    logic        r_out_user;
    logic [13:0] n_pitch;

    // whole pipeline moves on one enable; the last stage is the output register
    assign en              = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    // stages 1-3: products, sums and clamp test, cosine-squared remainder
    qte_products u_products (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_axis_tvalid),
        .i_w     (i_s_axis_tdata[15:0]),
        .i_x     (i_s_axis_tdata[31:16]),
        .i_y     (i_s_axis_tdata[47:32]),
        .i_z     (i_s_axis_tdata[63:48]),
        .o_valid (p_valid),
        .o_sinr  (p_sinr),
        .o_cosr  (p_cosr),
        .o_siny  (p_siny),
        .o_cosy  (p_cosy),
        .o_sinp  (p_sinp),
        .o_clamp (p_clamp),
        .o_rem   (p_rem)
    );

    // one root bit per stage for the asin cosine term
    qte_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (p_valid),
        .i_rem   (p_rem),
        .o_valid (s_valid),
        .o_root  (s_root)
    );

    // roll/yaw arguments and the pitch sine wait for the root
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_sinr[0] <= p_sinr;
            r_d_cosr[0] <= p_cosr;
            r_d_siny[0] <= p_siny;
            r_d_cosy[0] <= p_cosy;
            r_d_sinp[0] <= p_sinp;
            r_flag[0]   <= {p_sinp[AW-1], p_clamp};
            for (int k = 1; k < ISQ_STAGES; k++) begin
                r_d_sinr[k] <= r_d_sinr[k-1];
                r_d_cosr[k] <= r_d_cosr[k-1];
                r_d_siny[k] <= r_d_siny[k-1];
                r_d_cosy[k] <= r_d_cosy[k-1];
                r_d_sinp[k] <= r_d_sinp[k-1];
            end
            for (int k = 1; k < FLAG_DEPTH; k++) begin
                r_flag[k] <= r_flag[k-1];
            end
        end
    end

    // three parallel vectoring cordics
    qte_cordic #(.Steps(CORDIC_STEPS)) u_cordic_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_valid),
        .i_y     (r_d_sinr[ISQ_STAGES-1]),
        .i_x     (r_d_cosr[ISQ_STAGES-1]),
        .o_valid (c_roll_v),
        .o_angle (c_roll)
    );

    qte_cordic #(.Steps(CORDIC_STEPS)) u_cordic_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_valid),
        .i_y     (r_d_sinp[ISQ_STAGES-1]),
        .i_x     (t_arg'(s_root)),
        .o_valid (c_pitch_v),
        .o_angle (c_pitch)
    );

    qte_cordic #(.Steps(CORDIC_STEPS)) u_cordic_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_valid),
        .i_y     (r_d_siny[ISQ_STAGES-1]),
        .i_x     (r_d_cosy[ISQ_STAGES-1]),
        .o_valid (c_yaw_v),
        .o_angle (c_yaw)
    );

    // pitch: forced to +/-90 on a clamped argument, otherwise limited to +/-90
    always_comb begin
        if (r_flag[FLAG_DEPTH-1][0]) begin
            n_pitch = r_flag[FLAG_DEPTH-1][1] ? -14'(DEG90_OUT) : 14'(DEG90_OUT);
        end else if (c_pitch > t_ang'(DEG90_OUT)) begin
            n_pitch = 14'(DEG90_OUT);
        end else if (c_pitch < -t_ang'(DEG90_OUT)) begin
            n_pitch = -14'(DEG90_OUT);
        end else begin
            n_pitch = c_pitch[13:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= c_roll_v && c_pitch_v && c_yaw_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= {4'b0, c_yaw, n_pitch, c_roll};
            r_out_user <= r_flag[FLAG_DEPTH-1][0];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

endmodule
